// ----- rtl/mrfc_pkg.sv -----
package mrfc_pkg;

  // Field widths fixed by the frame format.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 10;
  localparam int unsigned CRC_W   = 16;

  // Frame constants.
  localparam logic [COUNT_W-1:0] COUNT_MAX      = 10'd1023;
  localparam logic [COUNT_W-1:0] MAX_RESET      = 10'd1000;
  localparam logic [COUNT_W-1:0] PAYLOAD_FIRST  = 10'd5;
  localparam logic [COUNT_W-1:0] MIN_FRAME      = 10'd4;
  localparam logic [CRC_W-1:0]   CRC_INIT       = 16'hFFFF;
  localparam logic [CRC_W-1:0]   CRC_POLY       = 16'hA001;

  // Result kinds.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Frame status codes.
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR   = 2'd1;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
  localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

  // One result beat.
  typedef struct packed {
    logic               kind;
    logic [BYTE_W-1:0]  payload_byte;
    logic [BYTE_W-1:0]  slave_id;
    logic [BYTE_W-1:0]  function_code;
    logic [1:0]         frame_status;
    logic [COUNT_W-1:0] payload_count;
    logic               last;
  } result_t;

  // Modbus CRC-16, one byte, reflected polynomial.
  function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                 input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ----- rtl/mrfc_in_if.sv -----
interface mrfc_in_if;
  logic                            valid;
  logic                            ready;
  logic [mrfc_pkg::BYTE_W-1:0]     rx_byte;
  logic                            frame_end;

  modport source (output valid, output rx_byte, output frame_end, input ready);
  modport sink   (input valid, input rx_byte, input frame_end, output ready);
endinterface

// ----- rtl/mrfc_out_if.sv -----
interface mrfc_out_if;
  logic                            valid;
  logic                            ready;
  logic                            kind;
  logic [mrfc_pkg::BYTE_W-1:0]     payload_byte;
  logic [mrfc_pkg::BYTE_W-1:0]     slave_id;
  logic [mrfc_pkg::BYTE_W-1:0]     function_code;
  logic [1:0]                      frame_status;
  logic [mrfc_pkg::COUNT_W-1:0]    payload_count;
  logic                            last;

  modport source (output valid, output kind, output payload_byte, output slave_id,
                  output function_code, output frame_status, output payload_count,
                  output last, input ready);
  modport sink   (input valid, input kind, input payload_byte, input slave_id,
                  input function_code, input frame_status, input payload_count,
                  input last, output ready);
endinterface

// ----- rtl/modbus_rtu_frame_checker.sv -----
// Modbus RTU frame checker. Each input beat is one received byte with a flag on
// the last byte of the frame. A byte is taken in every cycle while the output
// queue has room. It is held in the input register until the queue has room,
// and its results then enter the four-entry output queue. A byte gives at most
// a payload beat (frame bytes from index 3 on, once known not to be CRC bytes)
// and, on the last byte, a verdict beat. A byte that gives both gives two output
// beats, and the queue absorbs the extra beat. With the output ready the block
// sustains one byte per cycle. Input stalls only while the queue holds more than
// two beats, which happens only when the output is held off.
// Payload is streamed before the verdict: discard it when the status is not ok.
// The CRC is the standard Modbus CRC-16, low byte first on the wire. The
// length limit is written through cfg_we/cfg_wdata; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module modbus_rtu_frame_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  mrfc_in_if.sink                       in_ch,
  mrfc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [mrfc_pkg::COUNT_W-1:0]  cfg_wdata
);

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Length limit register.
  logic [mrfc_pkg::COUNT_W-1:0] max_bytes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= mrfc_pkg::MAX_RESET;
    end else if (cfg_we) begin
      max_bytes_r <= cfg_wdata;
    end
  end

  // Input register stage.
  logic                          stg_valid_r;
  logic [mrfc_pkg::BYTE_W-1:0]   stg_byte_r;
  logic                          stg_end_r;
  logic                          proc;
  logic [QCNT_W-1:0]             q_count_r;

  assign proc         = stg_valid_r && (q_count_r <= QCNT_W'(QDEPTH - 2));
  assign in_ch.ready  = !stg_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      stg_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      stg_byte_r <= in_ch.rx_byte;
      stg_end_r  <= in_ch.frame_end;
    end
  end

  // Frame state.
  logic [mrfc_pkg::CRC_W-1:0]    crc_r, crc_nxt;
  logic [mrfc_pkg::BYTE_W-1:0]   dly0_r, dly0_nxt, dly1_r, dly1_nxt;
  logic [mrfc_pkg::COUNT_W-1:0]  bcount_r, bcount_nxt;
  logic [mrfc_pkg::BYTE_W-1:0]   slave_r, slave_nxt, func_r, func_nxt;
  logic                          ovl_r, ovl_nxt;
  logic [mrfc_pkg::COUNT_W-1:0]  streamed_r, streamed_nxt;

  // Per-byte results.
  logic                          pay_en, ver_en;
  mrfc_pkg::result_t             pay_res, ver_res;
  logic [mrfc_pkg::CRC_W-1:0]    crc_acc;
  logic [mrfc_pkg::CRC_W-1:0]    crc_got;
  logic [mrfc_pkg::COUNT_W-1:0]  bc_upd;
  logic [mrfc_pkg::COUNT_W-1:0]  str_upd;
  logic [mrfc_pkg::BYTE_W-1:0]   slave_upd, func_upd;
  logic                          ovl_upd;
  logic [1:0]                    status;

  // Frame bookkeeping for the byte in the input register.
  always_comb begin
    crc_acc   = (bcount_r >= 10'd2) ? mrfc_pkg::crc_feed(crc_r, dly0_r) : crc_r;
    pay_en    = bcount_r >= mrfc_pkg::PAYLOAD_FIRST;
    str_upd   = (pay_en && (streamed_r < mrfc_pkg::COUNT_MAX)) ?
                streamed_r + 10'd1 : streamed_r;
    slave_upd = (bcount_r == 10'd0) ? stg_byte_r : slave_r;
    func_upd  = (bcount_r == 10'd1) ? stg_byte_r : func_r;
    bc_upd    = (bcount_r >= mrfc_pkg::COUNT_MAX) ? bcount_r : bcount_r + 10'd1;
    ovl_upd   = ovl_r || (bcount_r >= mrfc_pkg::COUNT_MAX) || (bc_upd > max_bytes_r);
    crc_got   = {stg_byte_r, dly1_r};
    ver_en    = stg_end_r;

    priority if (bc_upd < mrfc_pkg::MIN_FRAME) begin
      status = mrfc_pkg::STATUS_TOO_SHORT;
    end else if (ovl_upd) begin
      status = mrfc_pkg::STATUS_TOO_LONG;
    end else if (crc_got != crc_acc) begin
      status = mrfc_pkg::STATUS_CRC_ERR;
    end else begin
      status = mrfc_pkg::STATUS_OK;
    end

    pay_res               = '0;
    pay_res.kind          = mrfc_pkg::KIND_PAYLOAD;
    pay_res.payload_byte  = dly0_r;

    ver_res               = '0;
    ver_res.kind          = mrfc_pkg::KIND_VERDICT;
    ver_res.slave_id      = slave_upd;
    ver_res.function_code = func_upd;
    ver_res.frame_status  = status;
    ver_res.payload_count = str_upd;
    ver_res.last          = 1'b1;

    crc_nxt      = crc_r;
    dly0_nxt     = dly0_r;
    dly1_nxt     = dly1_r;
    bcount_nxt   = bcount_r;
    slave_nxt    = slave_r;
    func_nxt     = func_r;
    ovl_nxt      = ovl_r;
    streamed_nxt = streamed_r;
    if (proc) begin
      if (ver_en) begin
        crc_nxt      = mrfc_pkg::CRC_INIT;
        dly0_nxt     = '0;
        dly1_nxt     = '0;
        bcount_nxt   = '0;
        slave_nxt    = '0;
        func_nxt     = '0;
        ovl_nxt      = 1'b0;
        streamed_nxt = '0;
      end else begin
        crc_nxt      = crc_acc;
        dly0_nxt     = dly1_r;
        dly1_nxt     = stg_byte_r;
        bcount_nxt   = bc_upd;
        slave_nxt    = slave_upd;
        func_nxt     = func_upd;
        ovl_nxt      = ovl_upd;
        streamed_nxt = str_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r      <= mrfc_pkg::CRC_INIT;
      dly0_r     <= '0;
      dly1_r     <= '0;
      bcount_r   <= '0;
      slave_r    <= '0;
      func_r     <= '0;
      ovl_r      <= 1'b0;
      streamed_r <= '0;
    end else begin
      crc_r      <= crc_nxt;
      dly0_r     <= dly0_nxt;
      dly1_r     <= dly1_nxt;
      bcount_r   <= bcount_nxt;
      slave_r    <= slave_nxt;
      func_r     <= func_nxt;
      ovl_r      <= ovl_nxt;
      streamed_r <= streamed_nxt;
    end
  end

  // Output queue: up to two beats written per cycle, one read.
  mrfc_pkg::result_t  q_mem [QDEPTH];
  logic [QPTR_W-1:0]  q_wr_r, q_wr_nxt, q_rd_r, q_rd_nxt;
  logic [QCNT_W-1:0]  q_count_nxt;
  logic               q_pop;
  logic [1:0]         q_npush;

  assign q_pop   = out_ch.valid && out_ch.ready;
  assign q_npush = proc ? (2'(pay_en) + 2'(ver_en)) : 2'd0;

  always_comb begin
    q_wr_nxt    = q_wr_r + QPTR_W'(q_npush);
    q_rd_nxt    = q_rd_r + QPTR_W'(q_pop);
    q_count_nxt = q_count_r + QCNT_W'(q_npush) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_wr_r    <= '0;
      q_rd_r    <= '0;
      q_count_r <= '0;
    end else begin
      q_wr_r    <= q_wr_nxt;
      q_rd_r    <= q_rd_nxt;
      q_count_r <= q_count_nxt;
    end
  end

  // Payload beat goes first; the verdict follows it in the next slot.
  always_ff @(posedge clk) begin
    if (proc) begin
      if (pay_en) begin
        q_mem[q_wr_r] <= pay_res;
        if (ver_en) begin
          q_mem[q_wr_r + QPTR_W'(1)] <= ver_res;
        end
      end else if (ver_en) begin
        q_mem[q_wr_r] <= ver_res;
      end
    end
  end

  // Output channel.
  assign out_ch.valid         = q_count_r != '0;
  assign out_ch.kind          = q_mem[q_rd_r].kind;
  assign out_ch.payload_byte  = q_mem[q_rd_r].payload_byte;
  assign out_ch.slave_id      = q_mem[q_rd_r].slave_id;
  assign out_ch.function_code = q_mem[q_rd_r].function_code;
  assign out_ch.frame_status  = q_mem[q_rd_r].frame_status;
  assign out_ch.payload_count = q_mem[q_rd_r].payload_count;
  assign out_ch.last          = q_mem[q_rd_r].last;

`ifndef ASSERT_OFF
  // The queue never holds more beats than it has slots.
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count_r <= QCNT_W'(QDEPTH))
    else $error("output queue overflow");

  // A processed frame end leaves the frame state cleared.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (proc && stg_end_r) |=> (bcount_r == '0 && crc_r == mrfc_pkg::CRC_INIT &&
                             streamed_r == '0 && !ovl_r))
    else $error("frame state not cleared after verdict");

  // Streamed count never runs ahead of the byte count.
  a_stream: assert property (@(posedge clk) disable iff (!rst_n)
    streamed_r <= bcount_r)
    else $error("payload count exceeds byte count");

  // A stalled input register is not overwritten.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid_r && !proc) |=> (stg_valid_r && $stable(stg_byte_r) &&
                                $stable(stg_end_r)))
    else $error("input register lost a beat");
`endif

endmodule
